// ===== rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants
// widths, register indexes and transfer structs for the pd controller
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int ALPHA_W        = 16;
  localparam int STATE_W        = 32;

  localparam int CFG_W     = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX    = 3'd4;

  // gain times (possibly negated) sample
  localparam int PROD_W  = GAIN_W + DATA_WIDTH + 1;
  localparam int MCAND_W = (PROD_W > STATE_W) ? PROD_W : STATE_W;
  // multiplier operand: negated sample or (1 - alpha), both signed
  localparam int MULT_W  = (DATA_WIDTH + 1 > ALPHA_W + 2) ? DATA_WIDTH + 1 : ALPHA_W + 2;
  localparam int ACC_W   = MCAND_W + MULT_W + 1;
  localparam int CNT_W   = $clog2(MULT_W);
  localparam int SUM_W   = MCAND_W + 2;
  localparam int RND_W   = SUM_W - GAIN_FRAC_BITS;

  localparam int ROUND_ALPHA = 1 << (ALPHA_W - 1);
  localparam int ROUND_HALF  = (GAIN_FRAC_BITS > 0) ? (1 << (GAIN_FRAC_BITS - 1)) : 0;

  typedef struct packed {
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] angle_error;
    logic signed [DATA_WIDTH-1:0] turn_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         limited;
  } out_item_t;

  typedef struct packed {
    logic                      start;
    logic signed [ACC_W-1:0]   preload;
    logic signed [MCAND_W-1:0] mcand;
    logic signed [MULT_W-1:0]  mult;
  } mac_req_t;

endpackage

// ===== rtl/pdc_serial_mac.sv =====
// ----------------------------------------------------------------------------
// pdc_serial_mac: bit-serial multiply-accumulate
// acc = preload + mcand * mult, one multiplier bit per cycle, lsb first
// ----------------------------------------------------------------------------
module pdc_serial_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pdc_pkg::mac_req_t                   req,
  output logic                                done,
  output logic signed [pdc_pkg::ACC_W-1:0]    acc
);

  logic                               busy_r;
  logic                               done_r;
  logic [pdc_pkg::CNT_W-1:0]          cnt_r;
  logic [pdc_pkg::MULT_W-1:0]         mult_r;
  logic signed [pdc_pkg::ACC_W-1:0]   mcand_r;
  logic signed [pdc_pkg::ACC_W-1:0]   acc_r;
  logic signed [pdc_pkg::ACC_W-1:0]   acc_nxt;
  logic signed [pdc_pkg::ACC_W-1:0]   term;
  logic                               last;

  always_comb begin
    term = mult_r[0] ? mcand_r : '0;
    last = (cnt_r == pdc_pkg::CNT_W'(pdc_pkg::MULT_W - 1));
    // sign bit of the multiplier carries negative weight
    acc_nxt = last ? (acc_r - term) : (acc_r + term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r   <= req.preload;
      mcand_r <= pdc_pkg::ACC_W'(req.mcand);
      mult_r  <= req.mult;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      mcand_r <= mcand_r <<< 1;
      mult_r  <= mult_r >> 1;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("mac started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("mac done held more than one cycle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= pdc_pkg::CNT_W'(pdc_pkg::MULT_W - 1)))
    else $error("mac step count out of range");

endmodule

// ===== rtl/pd_controller_filtered_rate_damping_top.sv =====
// ----------------------------------------------------------------------------
// pd_controller_filtered_rate_damping_top: pd controller, filtered damping
// proportional term plus low-pass filtered rate damping, clamped drive output
// ----------------------------------------------------------------------------
// an update item runs its four products one after another through the one
//   bit-serial mac; a clear item skips them and goes straight to the finish
// the block takes no new item until the current result is loaded into the
//   output register
// reset: gains, alpha and limits return to their defaults, the filter state to
//   zero, no result pending; no clearing pass
module pd_controller_filtered_rate_damping_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pdc_pkg::in_item_t                  in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output pdc_pkg::out_item_t                 out_data,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdc_pkg::CFG_W-1:0]          cfg_data
);

  localparam int DW = pdc_pkg::DATA_WIDTH;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_P = 3'd1;  // prop_gain * angle_error
  localparam logic [2:0] ST_MUL_R = 3'd2;  // damp_gain * -turn_rate
  localparam logic [2:0] ST_MUL_A = 3'd3;  // alpha * filter state
  localparam logic [2:0] ST_MUL_B = 3'd4;  // (1 - alpha) * raw damping
  localparam logic [2:0] ST_FIN   = 3'd5;  // round, clamp, hand to output

  localparam logic [pdc_pkg::ALPHA_W:0] ALPHA_ONE =
    (pdc_pkg::ALPHA_W + 1)'(1) << pdc_pkg::ALPHA_W;
  localparam logic signed [pdc_pkg::SUM_W-1:0] HALF_LSB =
    pdc_pkg::SUM_W'(pdc_pkg::ROUND_HALF);

  logic [2:0]                               state_r, state_nxt;

  // configuration registers
  logic signed [pdc_pkg::GAIN_W-1:0]        prop_gain_r;
  logic signed [pdc_pkg::GAIN_W-1:0]        damp_gain_r;
  logic [pdc_pkg::ALPHA_W-1:0]              alpha_r;
  logic signed [DW-1:0]                     drive_min_r;
  logic signed [DW-1:0]                     drive_max_r;

  // item state
  logic signed [pdc_pkg::STATE_W-1:0]       y_r;      // filtered damping
  logic signed [pdc_pkg::PROD_W-1:0]        p_r;      // proportional term
  logic signed [pdc_pkg::PROD_W-1:0]        raw_r;    // raw damping term
  logic signed [DW-1:0]                     rate_r;
  logic                                     clear_r;

  // output register
  logic                                     out_valid_r;
  pdc_pkg::out_item_t                       out_data_r;

  pdc_pkg::mac_req_t                        mac_req;
  logic                                     mac_done;
  logic signed [pdc_pkg::ACC_W-1:0]         mac_acc;

  logic                                     in_xfer;
  logic                                     out_load;
  logic signed [pdc_pkg::MULT_W-1:0]        neg_rate;
  logic [pdc_pkg::ALPHA_W:0]                beta;
  logic signed [pdc_pkg::ACC_W-1:0]         acc_sh;
  logic                                     acc_fits;
  logic signed [pdc_pkg::STATE_W-1:0]       y_sat;
  logic signed [pdc_pkg::SUM_W-1:0]         sum;
  logic signed [pdc_pkg::RND_W-1:0]         rounded;
  logic signed [pdc_pkg::RND_W-1:0]         max_ext, min_ext;
  logic signed [pdc_pkg::RND_W-1:0]         clip_hi, clipped;
  pdc_pkg::out_item_t                       result;

  // one item in flight; the output register frees the input side early
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  assign neg_rate = -(pdc_pkg::MULT_W'(rate_r));
  assign beta     = ALPHA_ONE - {1'b0, alpha_r};

  // filter update: floor shift by the alpha fraction, then saturate to 32 bits
  always_comb begin
    acc_sh   = mac_acc >>> pdc_pkg::ALPHA_W;
    acc_fits = (&acc_sh[pdc_pkg::ACC_W-1:pdc_pkg::STATE_W-1]) ||
               !(|acc_sh[pdc_pkg::ACC_W-1:pdc_pkg::STATE_W-1]);
    if (acc_fits) begin
      y_sat = acc_sh[pdc_pkg::STATE_W-1:0];
    end else if (acc_sh[pdc_pkg::ACC_W-1]) begin
      y_sat = {1'b1, {(pdc_pkg::STATE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(pdc_pkg::STATE_W-1){1'b1}}};
    end
  end

  // mac sequencing: each done kicks off the next product
  always_comb begin
    mac_req   = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.mode) begin
            state_nxt = ST_FIN;
          end else begin
            mac_req.start = 1'b1;
            mac_req.mcand = pdc_pkg::MCAND_W'(prop_gain_r);
            mac_req.mult  = pdc_pkg::MULT_W'(in_data.angle_error);
            state_nxt     = ST_MUL_P;
          end
        end
      end
      ST_MUL_P: begin
        if (mac_done) begin
          mac_req.start = 1'b1;
          mac_req.mcand = pdc_pkg::MCAND_W'(damp_gain_r);
          mac_req.mult  = neg_rate;
          state_nxt     = ST_MUL_R;
        end
      end
      ST_MUL_R: begin
        if (mac_done) begin
          mac_req.start   = 1'b1;
          mac_req.preload = pdc_pkg::ACC_W'(pdc_pkg::ROUND_ALPHA);
          mac_req.mcand   = pdc_pkg::MCAND_W'(y_r);
          mac_req.mult    = pdc_pkg::MULT_W'({1'b0, alpha_r});
          state_nxt       = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        if (mac_done) begin
          // second product accumulates onto the first
          mac_req.start   = 1'b1;
          mac_req.preload = mac_acc;
          mac_req.mcand   = pdc_pkg::MCAND_W'(raw_r);
          mac_req.mult    = pdc_pkg::MULT_W'(beta);
          state_nxt       = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (mac_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // round half up, then max clamp followed by min clamp (min wins)
  always_comb begin
    sum     = pdc_pkg::SUM_W'(p_r) + pdc_pkg::SUM_W'(y_r) + HALF_LSB;
    rounded = pdc_pkg::RND_W'(sum >>> pdc_pkg::GAIN_FRAC_BITS);
    max_ext = pdc_pkg::RND_W'(drive_max_r);
    min_ext = pdc_pkg::RND_W'(drive_min_r);
    clip_hi = (rounded > max_ext) ? max_ext : rounded;
    clipped = (clip_hi < min_ext) ? min_ext : clip_hi;
    if (clear_r) begin
      result.drive   = '0;
      result.limited = 1'b0;
    end else begin
      result.drive   = clipped[DW-1:0];
      result.limited = (clipped != rounded);
    end
  end

  // control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prop_gain_r <= pdc_pkg::GAIN_W'(256);
      damp_gain_r <= '0;
      alpha_r     <= '0;
      drive_min_r <= {1'b1, {(DW-1){1'b0}}};
      drive_max_r <= {1'b0, {(DW-1){1'b1}}};
      y_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pdc_pkg::REG_PROP_GAIN:    prop_gain_r <= cfg_data[pdc_pkg::GAIN_W-1:0];
          pdc_pkg::REG_DAMP_GAIN:    damp_gain_r <= cfg_data[pdc_pkg::GAIN_W-1:0];
          pdc_pkg::REG_FILTER_ALPHA: alpha_r     <= cfg_data[pdc_pkg::ALPHA_W-1:0];
          pdc_pkg::REG_DRIVE_MIN:    drive_min_r <= cfg_data[DW-1:0];
          pdc_pkg::REG_DRIVE_MAX:    drive_max_r <= cfg_data[DW-1:0];
          default: begin
          end
        endcase
      end
      // clear item empties the filter; an update item stores the new value
      if (in_xfer && in_data.mode) begin
        y_r <= '0;
      end else if (state_r == ST_MUL_B && mac_done) begin
        y_r <= y_sat;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      clear_r <= in_data.mode;
      rate_r  <= in_data.turn_rate;
    end
    if (state_r == ST_MUL_P && mac_done) begin
      p_r <= mac_acc[pdc_pkg::PROD_W-1:0];
    end
    if (state_r == ST_MUL_R && mac_done) begin
      raw_r <= mac_acc[pdc_pkg::PROD_W-1:0];
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  pdc_serial_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // mac only reports back while a product is expected
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_MUL_P || state_r == ST_MUL_R ||
                  state_r == ST_MUL_A || state_r == ST_MUL_B))
    else $error("mac done outside a product state");

  // a clear item answers zero, unlimited
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && clear_r) |=> (out_data_r.drive == '0 && !out_data_r.limited))
    else $error("clear item gave a nonzero result");

  // a limited drive sits on one of the clamps
  a_limited_on_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.limited) |->
      (out_data_r.drive == drive_min_r || out_data_r.drive == drive_max_r))
    else $error("limited drive not at a clamp value");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pd_controller_filtered_rate_damping_top
// random and directed angle/rate samples go through a queue-fed driver; a
// bit-exact drive predictor with its own filter state and register copies
// checks every transfer on the result channel, in order, field by field
// ----------------------------------------------------------------------------
module tb;

  // run limit covers ~520 items, plus stalls and the long hold-off
  localparam int RUN_LIMIT   = 800_000;
  localparam int HOLD_CYCLES = 1200;
  localparam int DRAIN_WAIT  = 100;
  localparam int PHASE_ITEMS = 55;
  localparam logic [pdc_pkg::CFG_IDX_W-1:0] REG_FIRST_SPARE =
    pdc_pkg::REG_DRIVE_MAX + 1'b1;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  pdc_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pdc_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pdc_pkg::CFG_W-1:0]     cfg_data = '0;

  pd_controller_filtered_rate_damping_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copies of the controller registers, at their reset values
  longint gain_p     = 256;
  longint gain_d     = 0;
  longint alpha_w    = 0;
  longint lim_lo     = -32768;
  longint lim_hi     = 32767;
  longint damp_state = 0;   // low-pass filtered damping term, 8 fraction bits

  pdc_pkg::in_item_t  sample_q[$];     // samples waiting for the driver
  pdc_pkg::out_item_t drive_exp_q[$];  // predicted results, oldest first
  int        n_issued   = 0;
  int        n_accepted = 0;
  int        n_bad      = 0;
  int        cycles     = 0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_go        = 1'b0;
  int   hold_left      = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // drive for one sample; also advances the filter state
  function automatic pdc_pkg::out_item_t predict_drive(pdc_pkg::in_item_t s);
    longint    err;
    longint    rate;
    longint    prop;
    longint    raw;
    longint    acc;
    longint    sum;
    longint    rnd;
    longint    drv;
    pdc_pkg::out_item_t r;
    r = '0;
    if (s.mode == MODE_CLEAR) begin
      // clear empties the filter and answers zero, sample fields ignored
      damp_state = 0;
      return r;
    end
    err  = longint'(signed'(s.angle_error));
    rate = longint'(signed'(s.turn_rate));
    prop = gain_p * err;
    raw  = gain_d * (-rate);
    // y = alpha*y + (1 - alpha)*raw, round half up, floor shift by 16
    acc  = alpha_w * damp_state + (longint'(65536) - alpha_w) * raw + 32768;
    acc  = acc >>> pdc_pkg::ALPHA_W;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    damp_state = acc;
    sum = prop + damp_state;
    rnd = (sum + pdc_pkg::ROUND_HALF) >>> pdc_pkg::GAIN_FRAC_BITS;
    // max first, then min: crossed limits leave the minimum
    drv = rnd;
    if (drv > lim_hi) drv = lim_hi;
    if (drv < lim_lo) drv = lim_lo;
    r.drive   = drv[pdc_pkg::DATA_WIDTH-1:0];
    r.limited = (drv != rnd);
    return r;
  endfunction

  // input side: holds a stalled sample, otherwise offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        drive_exp_q.push_back(predict_drive(in_data));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall: random, or a long hold-off once requested
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (hold_go) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= hold_go || (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each result transfer with the oldest prediction
  pdc_pkg::out_item_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_exp_q.size() == 0) begin
        $error("result transfer with no prediction pending: drive %0d limited %0d",
               out_data.drive, out_data.limited);
        n_bad++;
      end else begin
        want = drive_exp_q.pop_front();
        if (out_data.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, out_data.drive);
          n_bad++;
        end
        if (out_data.limited !== want.limited) begin
          $error("limited: expected %0d, got %0d", want.limited, out_data.limited);
          n_bad++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one register write; leaves cfg_valid high so writes can go back to back
  task automatic set_reg(logic [pdc_pkg::CFG_IDX_W-1:0] idx,
                         logic [pdc_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pdc_pkg::REG_PROP_GAIN:
        gain_p  = longint'(signed'(val[pdc_pkg::GAIN_W-1:0]));
      pdc_pkg::REG_DAMP_GAIN:
        gain_d  = longint'(signed'(val[pdc_pkg::GAIN_W-1:0]));
      pdc_pkg::REG_FILTER_ALPHA:
        alpha_w = longint'(val[pdc_pkg::ALPHA_W-1:0]);
      pdc_pkg::REG_DRIVE_MIN:
        lim_lo  = longint'(signed'(val[pdc_pkg::DATA_WIDTH-1:0]));
      pdc_pkg::REG_DRIVE_MAX:
        lim_hi  = longint'(signed'(val[pdc_pkg::DATA_WIDTH-1:0]));
      default: ;  // spare indexes are ignored by the block
    endcase
  endtask

  task automatic add_sample(logic mode, logic [15:0] err, logic [15:0] rate);
    pdc_pkg::in_item_t s;
    s.mode        = mode;
    s.angle_error = err;
    s.turn_rate   = rate;
    sample_q.push_back(s);
    n_issued++;
  endtask

  // block is idle once every sample is taken and every result is back
  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_issued || drive_exp_q.size() != 0);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       pick_sample = 16'h8000;
      1:       pick_sample = 16'h7fff;
      2, 3:    pick_sample = 16'($urandom_range(600)) - 16'd300;
      4:       pick_sample = 16'($urandom_range(2)) - 16'd1;
      default: pick_sample = 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(4))
      0:       pick_gain = 16'h8000;
      1:       pick_gain = 16'h7fff;
      2:       pick_gain = 16'($urandom);
      default: pick_gain = 16'($urandom_range(1023)) - 16'd512;
    endcase
  endfunction

  function automatic logic [15:0] pick_alpha();
    case ($urandom_range(3))
      0:       pick_alpha = 16'h0000;
      1:       pick_alpha = 16'hffff;
      2:       pick_alpha = 16'($urandom);
      default: pick_alpha = 16'($urandom_range(65535, 49152));
    endcase
  endfunction

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // defaults: unity proportional gain, no damping, full-range limits
    add_sample(MODE_UPDATE, 16'h7fff, 16'h0000);
    add_sample(MODE_UPDATE, 16'h8000, 16'h0000);
    add_sample(MODE_UPDATE, 16'd100, -16'sd5);
    add_sample(MODE_CLEAR, 16'd1234, 16'd4321);
    add_sample(MODE_UPDATE, 16'hffff, 16'h7fff);
    wait_idle();

    // extreme gains, alpha zero passes damping straight through, tight clamp
    set_reg(pdc_pkg::REG_PROP_GAIN, 16'h8000);
    set_reg(pdc_pkg::REG_DAMP_GAIN, 16'h7fff);
    set_reg(pdc_pkg::REG_FILTER_ALPHA, 16'h0000);
    set_reg(pdc_pkg::REG_DRIVE_MIN, -16'sd100);
    set_reg(pdc_pkg::REG_DRIVE_MAX, 16'sd100);
    cfg_valid <= 1'b0;
    add_sample(MODE_UPDATE, 16'h8000, 16'h8000);
    add_sample(MODE_UPDATE, 16'h7fff, 16'h7fff);
    add_sample(MODE_UPDATE, 16'h0000, 16'h0001);
    add_sample(MODE_UPDATE, 16'h0001, 16'h0000);
    add_sample(MODE_UPDATE, 16'h8000, 16'h7fff);
    wait_idle();

    // heaviest filtering, crossed limits (minimum wins), clear mid-stream
    set_reg(pdc_pkg::REG_PROP_GAIN, 16'h7fff);
    set_reg(pdc_pkg::REG_DAMP_GAIN, 16'h8000);
    set_reg(pdc_pkg::REG_FILTER_ALPHA, 16'hffff);
    set_reg(pdc_pkg::REG_DRIVE_MIN, 16'sd50);
    set_reg(pdc_pkg::REG_DRIVE_MAX, -16'sd50);
    cfg_valid <= 1'b0;
    add_sample(MODE_UPDATE, 16'd0, 16'h7fff);
    add_sample(MODE_UPDATE, 16'd0, 16'h7fff);
    add_sample(MODE_UPDATE, 16'h8000, 16'h8000);
    add_sample(MODE_CLEAR, 16'h7fff, 16'h8000);
    add_sample(MODE_UPDATE, 16'd0, 16'd0);
    wait_idle();

    // half-gain rounding ties; spare register indexes must change nothing
    set_reg(pdc_pkg::REG_PROP_GAIN, 16'd128);
    set_reg(pdc_pkg::REG_DAMP_GAIN, 16'd0);
    set_reg(pdc_pkg::REG_FILTER_ALPHA, 16'd0);
    set_reg(pdc_pkg::REG_DRIVE_MIN, 16'h8000);
    set_reg(pdc_pkg::REG_DRIVE_MAX, 16'h7fff);
    for (int k = REG_FIRST_SPARE; k < (1 << pdc_pkg::CFG_IDX_W); k++) begin
      set_reg(pdc_pkg::CFG_IDX_W'(k), 16'h5a5a);
    end
    cfg_valid <= 1'b0;
    add_sample(MODE_UPDATE, 16'd1, 16'd0);
    add_sample(MODE_UPDATE, -16'sd1, 16'd0);
    add_sample(MODE_UPDATE, 16'd3, 16'd0);
    add_sample(MODE_UPDATE, -16'sd3, 16'd0);
    wait_idle();

    // --- random part: three idling profiles, three settings each ---
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct  = 36;
        recv_stall_pct = 76;
      end else if (ph < 6) begin
        send_idle_pct  = 76;
        recv_stall_pct = 36;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(3))
        0: begin      // full range
          lo = 16'h8000;
          hi = 16'h7fff;
        end
        1: begin      // narrow window, clamps often
          lo = -16'($urandom_range(2000));
          hi = 16'($urandom_range(2000));
        end
        2: begin      // crossed
          lo = 16'($urandom_range(3000, 1));
          hi = -16'($urandom_range(3000));
        end
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end
      endcase
      set_reg(pdc_pkg::REG_PROP_GAIN, pick_gain());
      set_reg(pdc_pkg::REG_DAMP_GAIN, pick_gain());
      set_reg(pdc_pkg::REG_FILTER_ALPHA, pick_alpha());
      set_reg(pdc_pkg::REG_DRIVE_MIN, lo);
      set_reg(pdc_pkg::REG_DRIVE_MAX, hi);
      cfg_valid <= 1'b0;
      // long result hold-off while the sender keeps offering, fills the block
      if (ph == 6) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        add_sample(($urandom_range(11) == 0) ? MODE_CLEAR : MODE_UPDATE,
                   pick_sample(), pick_sample());
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_bad == 0 && drive_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
